FILE: rtl/core/yuv420_rotate_address_generator_macros.svh
// Assertion macros for the YUV 4:2:0 rotate address generator.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef YUV420_ROTATE_ADDRESS_GENERATOR_MACROS_SVH
`define YUV420_ROTATE_ADDRESS_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YRAG_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define YRAG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/yrag_pkg.sv
package yrag_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Register field widths.
    localparam int DIM_CFG_W    = 13;
    localparam int ROT_W        = 2;
    localparam int STRIDE_W     = 16;
    localparam int PIX_STRIDE_W = 3;

    // Result field widths.
    localparam int PLANE_W      = 2;
    localparam int SRC_W        = 28;
    localparam int DST_W        = 25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH         = 3'd0,
        CFG_FRAME_HEIGHT        = 3'd1,
        CFG_ROTATION_MODE       = 3'd2,
        CFG_LUMA_ROW_STRIDE     = 3'd3,
        CFG_U_ROW_STRIDE        = 3'd4,
        CFG_V_ROW_STRIDE        = 3'd5,
        CFG_CHROMA_PIXEL_STRIDE = 3'd6
    } cfg_reg_t;

    typedef enum logic [PLANE_W-1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } plane_t;

    typedef enum logic [ROT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_mode_t;

    // Register values after reset.
    localparam logic [DIM_CFG_W-1:0]    RST_FRAME_WIDTH   = 13'd640;
    localparam logic [DIM_CFG_W-1:0]    RST_FRAME_HEIGHT  = 13'd480;
    localparam logic [STRIDE_W-1:0]     RST_ROW_STRIDE    = 16'd640;
    localparam logic [PIX_STRIDE_W-1:0] RST_PIXEL_STRIDE  = 3'd1;

endpackage

FILE: rtl/core/yuv420_rotate_address_generator.sv
// Channel   Handshake                    Payload
// -------   --------------------------   ------------------------------------------------
// config    cfg_wr_en                    cfg_index, cfg_data
// input     in_valid / in_stall          restart
// output    out_valid / out_stall        plane, source_offset, dest_offset, frame_end, last
//
// A luma item occupies the item register for one result and a chroma item for two, because
// the item register hands its U and V results to the single product stage one per cycle,
// while that stage is ready; each result then passes the product and result registers.
// Reset clears the counters and the pipeline valids and loads the register defaults.
// Stalls back up stage by stage; in_stall rises only when the item register cannot drain.

module yuv420_rotate_address_generator #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_wr_en,
    input  logic [yrag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yrag_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           restart,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [yrag_pkg::PLANE_W-1:0]   plane,
    output logic [yrag_pkg::SRC_W-1:0]     source_offset,
    output logic [yrag_pkg::DST_W-1:0]     dest_offset,
    output logic                           frame_end,
    output logic                           last
);

    import yrag_pkg::*;

    // Counters hold positions below MAX_DIM; dimensions need one more bit to hold MAX_DIM.
    localparam int              CNT_W     = $clog2(MAX_DIM);
    localparam int              DIM_W     = CNT_W + 1;
    localparam logic [31:0]     MAX_DIM_L = 32'(MAX_DIM);

    // ------------------------------------------------------------------------------------
    // Configuration registers. Writes beyond the register list are dropped.
    // ------------------------------------------------------------------------------------
    logic [DIM_CFG_W-1:0]    frame_width_reg;
    logic [DIM_CFG_W-1:0]    frame_height_reg;
    logic [ROT_W-1:0]        rotation_mode_reg;
    logic [STRIDE_W-1:0]     luma_row_stride_reg;
    logic [STRIDE_W-1:0]     u_row_stride_reg;
    logic [STRIDE_W-1:0]     v_row_stride_reg;
    logic [PIX_STRIDE_W-1:0] chroma_pixel_stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg         <= RST_FRAME_WIDTH;
            frame_height_reg        <= RST_FRAME_HEIGHT;
            rotation_mode_reg       <= ROT_0;
            luma_row_stride_reg     <= RST_ROW_STRIDE;
            u_row_stride_reg        <= RST_ROW_STRIDE;
            v_row_stride_reg        <= RST_ROW_STRIDE;
            chroma_pixel_stride_reg <= RST_PIXEL_STRIDE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:         frame_width_reg <= cfg_data[DIM_CFG_W-1:0];
                CFG_FRAME_HEIGHT:        frame_height_reg <= cfg_data[DIM_CFG_W-1:0];
                CFG_ROTATION_MODE:       rotation_mode_reg <= cfg_data[ROT_W-1:0];
                CFG_LUMA_ROW_STRIDE:     luma_row_stride_reg <= cfg_data[STRIDE_W-1:0];
                CFG_U_ROW_STRIDE:        u_row_stride_reg <= cfg_data[STRIDE_W-1:0];
                CFG_V_ROW_STRIDE:        v_row_stride_reg <= cfg_data[STRIDE_W-1:0];
                CFG_CHROMA_PIXEL_STRIDE: chroma_pixel_stride_reg <= cfg_data[PIX_STRIDE_W-1:0];
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------------------------
    // Frame geometry. Width and height are saturated into 2..MAX_DIM so that neither plane
    // is ever empty; the chroma plane is half size, rounded down.
    // ------------------------------------------------------------------------------------
    logic [31:0]      fw_ext;
    logic [31:0]      fh_ext;
    logic [DIM_W-1:0] w_dim;
    logic [DIM_W-1:0] h_dim;
    logic [DIM_W-1:0] hw_dim;
    logic [DIM_W-1:0] hh_dim;

    always_comb
    begin
        fw_ext = 32'(frame_width_reg);
        fh_ext = 32'(frame_height_reg);
        w_dim  = DIM_W'((fw_ext < 32'd2) ? 32'd2 : ((fw_ext > MAX_DIM_L) ? MAX_DIM_L : fw_ext));
        h_dim  = DIM_W'((fh_ext < 32'd2) ? 32'd2 : ((fh_ext > MAX_DIM_L) ? MAX_DIM_L : fh_ext));
        hw_dim = w_dim >> 1;
        hh_dim = h_dim >> 1;
    end

    // ------------------------------------------------------------------------------------
    // Pipeline handshake. Stage 0 is the item register, stage 1 holds the products and
    // stage 2 is the result register that drives the output ports.
    // ------------------------------------------------------------------------------------
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s0_chroma_reg;
    logic s0_sub_reg;
    logic s2_ready;
    logic s1_ready;
    logic s0_final;
    logic s0_emit;
    logic in_acc;

    always_comb
    begin
        s2_ready = !out_valid_reg || !out_stall;
        s1_ready = !s1_valid_reg || s2_ready;
        // A luma item has one result; a chroma item finishes once its V result leaves.
        s0_final = !s0_chroma_reg || s0_sub_reg;
        s0_emit  = s0_valid_reg && s1_ready;
        in_stall = s0_valid_reg && !(s1_ready && s0_final);
        in_acc   = in_valid && !in_stall;
    end

    // ------------------------------------------------------------------------------------
    // Raster counters. They advance when the item is accepted, so the item register only
    // needs the position that the item was given.
    // ------------------------------------------------------------------------------------
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] row_reg;
    logic             phase_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_next;
    logic             phase_next;

    logic [CNT_W-1:0] cur_x;
    logic [CNT_W-1:0] cur_y;
    logic             cur_phase;
    logic [DIM_W-1:0] cur_pw;
    logic [DIM_W-1:0] cur_ph;
    logic             row_end;
    logic             frame_done;

    always_comb
    begin
        // A restart puts the walk back at the first luma pixel before this item.
        cur_x      = restart ? '0 : col_reg;
        cur_y      = restart ? '0 : row_reg;
        cur_phase  = restart ? 1'b0 : phase_reg;
        cur_pw     = cur_phase ? hw_dim : w_dim;
        cur_ph     = cur_phase ? hh_dim : h_dim;
        row_end    = (DIM_W'(cur_x) + DIM_W'(1)) >= cur_pw;
        frame_done = row_end && ((DIM_W'(cur_y) + DIM_W'(1)) >= cur_ph);

        col_next   = col_reg;
        row_next   = row_reg;
        phase_next = phase_reg;
        if (in_acc)
        begin
            if (!row_end)
            begin
                col_next = cur_x + CNT_W'(1);
                row_next = cur_y;
                phase_next = cur_phase;
            end
            else if (!frame_done)
            begin
                col_next = '0;
                row_next = cur_y + CNT_W'(1);
                phase_next = cur_phase;
            end
            else
            begin
                // The last position of a plane flips between the luma and chroma walks.
                col_next = '0;
                row_next = '0;
                phase_next = !cur_phase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stage 0: item register. A chroma item stays on after its U slot to hand on its V slot.
    // ------------------------------------------------------------------------------------
    logic [CNT_W-1:0] s0_x_reg;
    logic [CNT_W-1:0] s0_y_reg;
    logic             s0_fdone_reg;
    logic             s0_valid_next;
    logic             s0_sub_next;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        s0_sub_next   = s0_sub_reg;
        if (in_acc)
        begin
            s0_valid_next = 1'b1;
            s0_sub_next   = 1'b0;
        end
        else if (s0_emit)
        begin
            if (s0_final)
            begin
                s0_valid_next = 1'b0;
            end
            else
            begin
                s0_sub_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s0_sub_reg   <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= s0_valid_next;
            s0_sub_reg   <= s0_sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s0_x_reg      <= cur_x;
            s0_y_reg      <= cur_y;
            s0_chroma_reg <= cur_phase;
            s0_fdone_reg  <= frame_done;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stage 0 to 1: the offset products. The destination position is a * b + c where the
    // rotation picks which of x, y and the mirrored coordinates play each role.
    // ------------------------------------------------------------------------------------
    plane_t               slot_plane;
    logic [STRIDE_W-1:0]  slot_stride;
    logic [DIM_W-1:0]     slot_pw;
    logic [DIM_W-1:0]     slot_ph;
    logic [DST_W-1:0]     xe;
    logic [DST_W-1:0]     ye;
    logic [DST_W-1:0]     we;
    logic [DST_W-1:0]     he;
    logic [DST_W-1:0]     rot_a;
    logic [DST_W-1:0]     rot_b;
    logic [DST_W-1:0]     rot_c;
    logic [SRC_W-1:0]     src_prod;
    logic [SRC_W-1:0]     src_add;
    logic [DST_W-1:0]     rot_prod;
    logic [DST_W-1:0]     luma_size;
    logic [DST_W-1:0]     chroma_size;

    always_comb
    begin
        if (!s0_chroma_reg)
        begin
            slot_plane = PLANE_Y;
        end
        else if (s0_sub_reg)
        begin
            slot_plane = PLANE_V;
        end
        else
        begin
            slot_plane = PLANE_U;
        end

        case (slot_plane)
            PLANE_Y: slot_stride = luma_row_stride_reg;
            PLANE_U: slot_stride = u_row_stride_reg;
            default: slot_stride = v_row_stride_reg;
        endcase

        src_prod = SRC_W'(s0_y_reg) * SRC_W'(slot_stride);
        src_add  = s0_chroma_reg ? SRC_W'(s0_x_reg) * SRC_W'(chroma_pixel_stride_reg)
                                 : SRC_W'(s0_x_reg);

        slot_pw = s0_chroma_reg ? hw_dim : w_dim;
        slot_ph = s0_chroma_reg ? hh_dim : h_dim;
        xe = DST_W'(s0_x_reg);
        ye = DST_W'(s0_y_reg);
        we = DST_W'(slot_pw);
        he = DST_W'(slot_ph);

        // Mirrored coordinates wrap modulo the field width if a counter is out of range.
        case (rot_mode_t'(rotation_mode_reg))
            ROT_0:
            begin
                rot_a = ye;
                rot_b = we;
                rot_c = xe;
            end
            ROT_90:
            begin
                rot_a = xe;
                rot_b = he;
                rot_c = he - DST_W'(1) - ye;
            end
            ROT_180:
            begin
                rot_a = he - DST_W'(1) - ye;
                rot_b = we;
                rot_c = we - DST_W'(1) - xe;
            end
            default:
            begin
                rot_a = we - DST_W'(1) - xe;
                rot_b = he;
                rot_c = ye;
            end
        endcase

        rot_prod    = rot_a * rot_b;
        luma_size   = DST_W'(w_dim) * DST_W'(h_dim);
        chroma_size = DST_W'(hw_dim) * DST_W'(hh_dim);
    end

    // ------------------------------------------------------------------------------------
    // Stage 1: product register.
    // ------------------------------------------------------------------------------------
    plane_t           s1_plane_reg;
    logic [SRC_W-1:0] s1_src_prod_reg;
    logic [SRC_W-1:0] s1_src_add_reg;
    logic [DST_W-1:0] s1_rot_prod_reg;
    logic [DST_W-1:0] s1_rot_add_reg;
    logic [DST_W-1:0] s1_base_reg;
    logic [DST_W-1:0] s1_vbase_reg;
    logic             s1_frame_end_reg;
    logic             s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_emit)
        begin
            s1_plane_reg     <= slot_plane;
            s1_src_prod_reg  <= src_prod;
            s1_src_add_reg   <= src_add;
            s1_rot_prod_reg  <= rot_prod;
            s1_rot_add_reg   <= rot_c;
            // U and V sit after the luma plane; V also after the U plane.
            s1_base_reg      <= (slot_plane != PLANE_Y) ? luma_size : '0;
            s1_vbase_reg     <= (slot_plane == PLANE_V) ? chroma_size : '0;
            s1_frame_end_reg <= s0_chroma_reg && s0_sub_reg && s0_fdone_reg;
            s1_last_reg      <= s0_final;
        end
    end

    // ------------------------------------------------------------------------------------
    // Stage 2: result register. Sums are taken modulo the output field widths.
    // ------------------------------------------------------------------------------------
    plane_t           out_plane_reg;
    logic [SRC_W-1:0] out_src_reg;
    logic [DST_W-1:0] out_dst_reg;
    logic             out_frame_end_reg;
    logic             out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            out_plane_reg     <= s1_plane_reg;
            out_src_reg       <= s1_src_prod_reg + s1_src_add_reg;
            out_dst_reg       <= s1_rot_prod_reg + s1_rot_add_reg + s1_base_reg + s1_vbase_reg;
            out_frame_end_reg <= s1_frame_end_reg;
            out_last_reg      <= s1_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign plane         = out_plane_reg;
    assign source_offset = out_src_reg;
    assign dest_offset   = out_dst_reg;
    assign frame_end     = out_frame_end_reg;
    assign last          = out_last_reg;

endmodule

FILE: rtl/core/yrag_checker.sv
`include "yuv420_rotate_address_generator_macros.svh"

module yrag_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            restart,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [yrag_pkg::PLANE_W-1:0]    plane,
    input logic [yrag_pkg::SRC_W-1:0]      source_offset,
    input logic [yrag_pkg::DST_W-1:0]      dest_offset,
    input logic                            frame_end,
    input logic                            last
);

    import yrag_pkg::*;

    // A stalled input item stays offered with the same payload.
    `YRAG_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(restart), "stalled item changed")

    // A stalled result keeps its whole payload.
    `YRAG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(plane) && $stable(source_offset) && $stable(dest_offset) && $stable(frame_end) && $stable(last), "stalled result changed")

    // The V result of a chroma item follows its U result directly.
    `YRAG_ASSERT_NEXT(a_u_then_v, out_valid && !out_stall && plane == PLANE_U, out_valid && plane == PLANE_V, "U result not followed by V result")

    // Only the U result leaves its item unfinished.
    `YRAG_ASSERT_IMPLY(a_last_by_plane, out_valid, last == (plane != PLANE_U), "last flag does not match plane")

    // The frame ends on a V result that closes its item.
    `YRAG_ASSERT_IMPLY(a_frame_end_on_v, out_valid && frame_end, plane == PLANE_V && last, "frame end outside a final V result")

endmodule

bind yuv420_rotate_address_generator yrag_checker u_yrag_checker (.*);
